[design/bdpc_pkg.sv]
`default_nettype none
package bdpc_pkg;

	localparam int PIN_FIELD_BITS = 3;
	localparam int INDEX_BITS     = 3;
	localparam int BUTTON_SLOTS   = 1 << INDEX_BITS;
	localparam int COUNT_BITS     = 16;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic [1:0]                kind_t;
	typedef logic [PIN_FIELD_BITS-1:0] pins_t;
	typedef logic [INDEX_BITS-1:0]     button_idx_t;
	typedef logic [COUNT_BITS-1:0]     count_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam kind_t KIND_TICK       = 2'd0;
	localparam kind_t KIND_READ_SHORT = 2'd1;
	localparam kind_t KIND_READ_LONG  = 2'd2;

	localparam cfg_index_t REG_LONG_PRESS = 2'd0;
	localparam cfg_index_t REG_REPEAT     = 2'd1;

	localparam count_t LONG_PRESS_RESET = 16'd100;
	localparam count_t REPEAT_RESET     = 16'd25;

	typedef struct packed {
		logic tick;
		logic has_pin;
		logic sample;
		logic clr_short;
		logic clr_long;
	} lane_cmd_t;

	typedef struct packed {
		logic short_flag;
		logic long_flag;
	} lane_flags_t;

endpackage
`default_nettype wire

[design/bdpc_in_if.sv]
`default_nettype none
interface bdpc_in_if;
	import bdpc_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       kind;
	pins_t       pin_levels;
	button_idx_t button_index;

	modport source (output valid, kind, pin_levels, button_index, input ready);
	modport sink (input valid, kind, pin_levels, button_index, output ready);

endinterface
`default_nettype wire

[design/bdpc_out_if.sv]
`default_nettype none
interface bdpc_out_if;

	logic valid;
	logic ready;
	logic answer;

	modport source (output valid, answer, input ready);
	modport sink (input valid, answer, output ready);

endinterface
`default_nettype wire

[design/bdpc_cfg_if.sv]
`default_nettype none
interface bdpc_cfg_if;
	import bdpc_pkg::*;

	logic       valid;
	logic       ready;
	cfg_index_t index;
	count_t     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);

endinterface
`default_nettype wire

[design/button_debounce_press_classifier_unit.sv]
// Debouncer and short/long press classifier for up to eight active-low buttons.
// Items arrive on the item channel; every accepted beat gives exactly one beat on
// the result channel. A tick beat shifts each button's raw pin into its two-sample
// history and updates the hold and repeat counters; its answer is 0. A read beat
// returns the short or long flag of the selected button and clears it; an index
// past the last button, or an unused kind, answers 0 and changes nothing.
// Each button has its own lane that updates in the cycle the beat is accepted,
// and the answer is registered, so a result appears in the cycle after acceptance.
// One beat is taken every cycle as long as the result register is empty or is
// being drained in the same cycle; a stalled receiver holds the pending result
// and blocks new items only while it stays stalled.
// The cfg channel is always ready; index 0 sets the long-press count and index 1
// the repeat period, other indexes are ignored. Write it only while idle.
// Reset clears all button state and loads counts of 100 and 25 ticks.
`default_nettype none
module button_debounce_press_classifier_unit #(
	parameter int NUM_BUTTONS = 3
) (
	input wire         clk,
	input wire         arst_n,
	bdpc_in_if.sink    item,
	bdpc_out_if.source result,
	bdpc_cfg_if.sink   cfg
);
	import bdpc_pkg::*;

	count_t long_ticks_q, repeat_ticks_q;
	logic   valid_q, answer_q;
	logic   accept;
	logic   is_tick, is_read_short, is_read_long;
	logic   answer_d;

	logic [BUTTON_SLOTS-1:0] short_vec, long_vec;
	lane_flags_t             lane_flags [NUM_BUTTONS];

	assign cfg.ready  = 1'b1;
	assign item.ready = !valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q   <= LONG_PRESS_RESET;
			repeat_ticks_q <= REPEAT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LONG_PRESS: long_ticks_q   <= cfg.data;
				REG_REPEAT:     repeat_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_tick       = 1'b0;
		is_read_short = 1'b0;
		is_read_long  = 1'b0;
		unique case (item.kind)
			KIND_TICK:       is_tick       = 1'b1;
			KIND_READ_SHORT: is_read_short = 1'b1;
			KIND_READ_LONG:  is_read_long  = 1'b1;
			default: ;
		endcase
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		lane_cmd_t cmd;
		logic      selected;

		assign selected      = item.button_index == INDEX_BITS'(b);
		assign cmd.tick      = accept && is_tick;
		assign cmd.clr_short = accept && is_read_short && selected;
		assign cmd.clr_long  = accept && is_read_long && selected;

		if (b < PIN_FIELD_BITS) begin : g_pin
			assign cmd.has_pin = 1'b1;
			assign cmd.sample  = item.pin_levels[b];
		end else begin : g_no_pin
			assign cmd.has_pin = 1'b0;
			assign cmd.sample  = 1'b0;
		end

		bdpc_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.long_ticks   (long_ticks_q),
			.repeat_ticks (repeat_ticks_q),
			.flags        (lane_flags[b])
		);
	end

	for (genvar s = 0; s < BUTTON_SLOTS; s++) begin : g_slot
		if (s < NUM_BUTTONS) begin : g_used
			assign short_vec[s] = lane_flags[s].short_flag;
			assign long_vec[s]  = lane_flags[s].long_flag;
		end else begin : g_unused
			assign short_vec[s] = 1'b0;
			assign long_vec[s]  = 1'b0;
		end
	end

	assign answer_d = (is_read_short && short_vec[item.button_index])
		|| (is_read_long && long_vec[item.button_index]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item.ready) begin
			valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			answer_q <= answer_d;
		end
	end

	assign result.valid  = valid_q;
	assign result.answer = answer_q;

endmodule
`default_nettype wire

[design/bdpc_lane.sv]
`default_nettype none
module bdpc_lane (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bdpc_pkg::lane_cmd_t   cmd,
	input  bdpc_pkg::count_t      long_ticks,
	input  bdpc_pkg::count_t      repeat_ticks,
	output bdpc_pkg::lane_flags_t flags
);
	import bdpc_pkg::*;

	logic   newest_q, prev_q, short_q, long_q;
	count_t hold_q, rep_q;

	logic   newest_d, older_d, prev_d, short_d, long_d;
	count_t hold_d, rep_d;
	count_t rep_inc;

	always_comb begin
		newest_d = newest_q;
		older_d  = newest_q;
		prev_d   = prev_q;
		short_d  = short_q;
		long_d   = long_q;
		hold_d   = hold_q;
		rep_d    = rep_q;
		rep_inc  = rep_q + 16'd1;

		if (cmd.tick) begin
			newest_d = cmd.has_pin ? cmd.sample : newest_q;
			if (newest_d == older_d) begin
				if (!newest_d) begin
					if (hold_q < long_ticks) begin
						hold_d = hold_q + 16'd1;
						if (hold_d == long_ticks) begin
							long_d  = 1'b1;
							short_d = 1'b0;
							rep_d   = '0;
						end
					end else begin
						rep_d = rep_inc;
						if (rep_inc >= repeat_ticks) begin
							short_d = 1'b0;
							long_d  = 1'b1;
							rep_d   = '0;
						end
					end
				end else if (!prev_q) begin
					if (hold_q != '0 && hold_q < long_ticks) begin
						short_d = 1'b1;
					end
					hold_d = '0;
					rep_d  = '0;
					long_d = 1'b0;
				end
				prev_d = newest_d;
			end
		end

		if (cmd.clr_short) begin
			short_d = 1'b0;
		end
		if (cmd.clr_long) begin
			long_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= 1'b0;
			prev_q   <= 1'b0;
			short_q  <= 1'b0;
			long_q   <= 1'b0;
			hold_q   <= '0;
			rep_q    <= '0;
		end else begin
			newest_q <= newest_d;
			prev_q   <= prev_d;
			short_q  <= short_d;
			long_q   <= long_d;
			hold_q   <= hold_d;
			rep_q    <= rep_d;
		end
	end

	assign flags.short_flag = short_q;
	assign flags.long_flag  = long_q;

endmodule
`default_nettype wire

[sim/button_debounce_press_classifier_unit_test.sv]
`timescale 1ns / 100ps

module button_debounce_press_classifier_unit_test;
	import bdpc_pkg::*;

	localparam int NUM_BUTTONS = 3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	localparam kind_t      KIND_UNUSED  = 2'd3;
	localparam cfg_index_t REG_SPARE_LO = 2'd2;
	localparam cfg_index_t REG_SPARE_HI = 2'd3;

	localparam logic PRESSED  = 1'b0;
	localparam logic RELEASED = 1'b1;

	logic clk;
	logic arst_n;

	bdpc_in_if  press_items ();
	bdpc_out_if press_answers ();
	bdpc_cfg_if reg_writes ();

	button_debounce_press_classifier_unit #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(press_items),
		.result(press_answers),
		.cfg(reg_writes)
	);

	// Mirror of the per-button debounce and classifier state.
	count_t long_press_limit = LONG_PRESS_RESET;
	count_t repeat_period    = REPEAT_RESET;
	logic   btn_newest   [NUM_BUTTONS] = '{default: PRESSED};
	logic   btn_older    [NUM_BUTTONS] = '{default: PRESSED};
	logic   btn_stable   [NUM_BUTTONS] = '{default: PRESSED};
	logic   btn_prev     [NUM_BUTTONS] = '{default: PRESSED};
	count_t btn_hold     [NUM_BUTTONS] = '{default: '0};
	count_t btn_repeat   [NUM_BUTTONS] = '{default: '0};
	logic   btn_short    [NUM_BUTTONS] = '{default: 1'b0};
	logic   btn_long     [NUM_BUTTONS] = '{default: 1'b0};

	logic expected_answers [$];
	int   failures = 0;
	int   quiet_cycles = 0;
	bit   gaps_on = 1'b1;
	bit   stalls_on = 1'b1;
	int   stall_left = 0;

	logic pin_target [PIN_FIELD_BITS] = '{default: RELEASED};
	int   dwell      [PIN_FIELD_BITS] = '{default: 0};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic classify_item(kind_t k, pins_t pins, button_idx_t idx);
		logic flag;
		flag = 1'b0;
		if (k == KIND_TICK) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				btn_older[b] = btn_newest[b];
				if (b < PIN_FIELD_BITS)
					btn_newest[b] = pins[b];
				if (btn_newest[b] != btn_older[b])
					continue;
				btn_stable[b] = btn_newest[b];
				if (btn_stable[b] == PRESSED) begin
					if (btn_hold[b] < long_press_limit) begin
						btn_hold[b] = btn_hold[b] + 1'b1;
						if (btn_hold[b] == long_press_limit) begin
							btn_long[b]   = 1'b1;
							btn_short[b]  = 1'b0;
							btn_repeat[b] = '0;
						end
					end else begin
						btn_repeat[b] = btn_repeat[b] + 1'b1;
						if (btn_repeat[b] >= repeat_period) begin
							btn_short[b]  = 1'b0;
							btn_long[b]   = 1'b1;
							btn_repeat[b] = '0;
						end
					end
				end
				if (btn_stable[b] == RELEASED && btn_prev[b] == PRESSED) begin
					if (btn_hold[b] > 0 && btn_hold[b] < long_press_limit)
						btn_short[b] = 1'b1;
					btn_hold[b]   = '0;
					btn_repeat[b] = '0;
					btn_long[b]   = 1'b0;
				end
				btn_prev[b] = btn_stable[b];
			end
		end else if (k == KIND_READ_SHORT || k == KIND_READ_LONG) begin
			if (idx < NUM_BUTTONS) begin
				if (k == KIND_READ_SHORT) begin
					flag = btn_short[idx];
					btn_short[idx] = 1'b0;
				end else begin
					flag = btn_long[idx];
					btn_long[idx] = 1'b0;
				end
			end
		end
		return flag;
	endfunction

	always @(posedge clk) begin
		logic want;
		if (arst_n) begin
			if (reg_writes.valid && reg_writes.ready) begin
				case (reg_writes.index)
					REG_LONG_PRESS: long_press_limit = reg_writes.data;
					REG_REPEAT:     repeat_period = reg_writes.data;
					default: ;
				endcase
			end
			if (press_items.valid && press_items.ready)
				expected_answers.push_back(classify_item(press_items.kind,
					press_items.pin_levels, press_items.button_index));
			if (press_answers.valid && press_answers.ready) begin
				if (expected_answers.size() == 0) begin
					if (failures < MAX_REPORTS)
						$display("%0t: answer %0b arrived with nothing outstanding",
							$realtime, press_answers.answer);
					failures++;
				end else begin
					want = expected_answers.pop_front();
					if (press_answers.answer !== want) begin
						if (failures < MAX_REPORTS)
							$display("%0t: answer mismatch, expected %0b, got %0b",
								$realtime, want, press_answers.answer);
						failures++;
					end
				end
			end
		end
	end

	// A run with no beat moving on any channel for too long is hung.
	always @(posedge clk) begin
		if ((press_items.valid && press_items.ready) ||
				(press_answers.valid && press_answers.ready) ||
				(reg_writes.valid && reg_writes.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		press_answers.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				press_answers.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				press_answers.ready <= 1'b0;
			end else begin
				press_answers.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input kind_t k, input pins_t pins, input button_idx_t idx);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			press_items.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		press_items.valid        <= 1'b1;
		press_items.kind         <= k;
		press_items.pin_levels   <= pins;
		press_items.button_index <= idx;
		do @(posedge clk); while (!press_items.ready);
	endtask

	task automatic drain_answers();
		@(negedge clk);
		press_items.valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t reg_index, input count_t value);
		@(negedge clk);
		reg_writes.valid <= 1'b1;
		reg_writes.index <= reg_index;
		reg_writes.data  <= value;
		do @(posedge clk); while (!reg_writes.ready);
		@(negedge clk);
		reg_writes.valid <= 1'b0;
	endtask

	task automatic set_counts(input count_t long_ticks, input count_t repeat_ticks);
		drain_answers();
		write_register(REG_LONG_PRESS, long_ticks);
		write_register(REG_REPEAT, repeat_ticks);
	endtask

	task automatic test_reset_state();
		send_item(KIND_READ_SHORT, 3'b000, 3'd0);
		send_item(KIND_READ_LONG, 3'b000, 3'd2);
		send_item(KIND_READ_LONG, 3'b000, 3'd7);
		send_item(KIND_READ_SHORT, 3'b000, 3'd3);
		send_item(KIND_UNUSED, 3'b111, 3'd7);
		send_item(KIND_TICK, 3'b111, 3'd0);
		send_item(KIND_TICK, 3'b111, 3'd0);
	endtask

	task automatic test_short_and_long();
		set_counts(16'd3, 16'd2);
		send_item(KIND_TICK, 3'b110, 3'd0);
		send_item(KIND_TICK, 3'b110, 3'd0);
		send_item(KIND_TICK, 3'b111, 3'd0);
		send_item(KIND_TICK, 3'b111, 3'd0);
		send_item(KIND_READ_SHORT, 3'b000, 3'd0);
		repeat (4) send_item(KIND_TICK, 3'b110, 3'd0);
		send_item(KIND_READ_LONG, 3'b000, 3'd0);
		repeat (2) send_item(KIND_TICK, 3'b110, 3'd0);
		send_item(KIND_READ_LONG, 3'b000, 3'd0);
		repeat (2) send_item(KIND_TICK, 3'b111, 3'd0);
		send_item(KIND_READ_LONG, 3'b000, 3'd0);
	endtask

	task automatic test_zero_counts();
		set_counts(16'd0, 16'd0);
		write_register(REG_SPARE_LO, 16'hFFFF);
		write_register(REG_SPARE_HI, 16'hFFFF);
		repeat (2) send_item(KIND_TICK, 3'b000, 3'd0);
		send_item(KIND_READ_LONG, 3'b000, 3'd1);
		repeat (2) send_item(KIND_TICK, 3'b111, 3'd0);
		send_item(KIND_READ_SHORT, 3'b000, 3'd1);
	endtask

	// Each pin follows press and release runs of random length with
	// occasional single-tick bounce, and reads are mixed in.
	task automatic drive_random_items(input int count, input int max_dwell);
		pins_t       pins;
		kind_t       k;
		button_idx_t idx;
		int          roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			pins = pins_t'($urandom);
			idx  = button_idx_t'($urandom);
			if (roll < 60) begin
				k = KIND_TICK;
				for (int b = 0; b < PIN_FIELD_BITS; b++) begin
					if (dwell[b] == 0) begin
						pin_target[b] = ~pin_target[b];
						dwell[b] = $urandom_range(1, max_dwell);
					end
					dwell[b]--;
					pins[b] = ($urandom_range(0, 11) == 0) ? ~pin_target[b] : pin_target[b];
				end
			end else if (roll < 96) begin
				k = ($urandom_range(0, 1) == 0) ? KIND_READ_SHORT : KIND_READ_LONG;
				if ($urandom_range(0, 4) != 0)
					idx = button_idx_t'($urandom_range(0, NUM_BUTTONS - 1));
			end else begin
				k = KIND_UNUSED;
			end
			send_item(k, pins, idx);
		end
	endtask

	task automatic test_random_presses();
		set_counts(16'd1, 16'd1);
		drive_random_items(70, 6);
		set_counts(16'd12, 16'd4);
		drive_random_items(80, 30);
		set_counts(16'd2, 16'hFFFF);
		drive_random_items(70, 8);
		set_counts(16'hFFFF, 16'd3);
		drive_random_items(60, 20);
		set_counts(16'd0, 16'd5);
		drive_random_items(70, 20);
		set_counts(16'd6, 16'd0);
		drive_random_items(80, 16);
	endtask

	task automatic test_back_to_back();
		set_counts(16'd5, 16'd2);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		drive_random_items(70, 12);
	endtask

	initial begin
		arst_n = 1'b0;
		press_items.valid        = 1'b0;
		press_items.kind         = KIND_TICK;
		press_items.pin_levels   = '0;
		press_items.button_index = '0;
		reg_writes.valid = 1'b0;
		reg_writes.index = REG_LONG_PRESS;
		reg_writes.data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_short_and_long();
		test_zero_counts();
		test_random_presses();
		test_back_to_back();

		drain_answers();
		repeat (5) @(posedge clk);
		if (failures == 0 && expected_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
design/bdpc_pkg.sv
design/bdpc_in_if.sv
design/bdpc_out_if.sv
design/bdpc_cfg_if.sv
design/bdpc_lane.sv
design/button_debounce_press_classifier_unit.sv
sim/button_debounce_press_classifier_unit_test.sv
